// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition that must never be true
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== rtl/u2u8_pkg.sv =====
`timescale 1ns / 1ps

package u2u8_pkg;

    // queue depth between front and back
    localparam int unsigned QueueDepth = 2;
    // most bytes one code unit can cause
    localparam int unsigned MaxBytes   = 6;

    localparam logic [15:0] Lim1Byte = 16'h0080;
    localparam logic [15:0] Lim2Byte = 16'h0800;
    localparam logic [15:0] HighBase = 16'hD800;
    localparam logic [15:0] LowBase  = 16'hDC00;
    localparam logic [15:0] SurrEnd  = 16'hE000;
    localparam logic [20:0] SuppBase = 21'h010000;

    typedef logic [7:0] t_byte;

    // one encoded unit: byte 0 goes out first
    typedef struct packed {
        t_byte [MaxBytes-1:0] bytes;
        logic  [2:0]          nbytes;
    } t_job;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // three-byte form of a 16-bit value
    function automatic logic [2:0][7:0] enc3(input logic [15:0] v);
        logic [2:0][7:0] b;
        b[0] = {4'hE, v[15:12]};
        b[1] = {2'b10, v[11:6]};
        b[2] = {2'b10, v[5:0]};
        return b;
    endfunction

    // four-byte form of a supplementary code point
    function automatic logic [3:0][7:0] enc4(input logic [20:0] cp);
        logic [3:0][7:0] b;
        b[0] = {5'b11110, cp[20:18]};
        b[1] = {2'b10, cp[17:12]};
        b[2] = {2'b10, cp[11:6]};
        b[3] = {2'b10, cp[5:0]};
        return b;
    endfunction

endpackage

// ===== rtl/utf16_to_utf8_transcoder_unit.sv =====
// channel  | dir | tdata                  | tlast
// s_axis   | in  | [15:0] code_unit       | final_unit
// m_axis   | out | [7:0]  out_byte        | unit_end
//
// A code unit is taken in any cycle in which the queue has room; it then
// yields 0 to 6 bytes, sent at one byte per cycle by the output serialiser
// while the output is ready (3 bytes at most unless a surrogate was held).
// The first byte passes through the queue and then the output register.
// Reset clears the held surrogate, queue pointers and output valid.
// Either side may stall; the queue lets the input run on while bytes wait.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf16_to_utf8_transcoder_unit import u2u8_pkg::*; #(
    parameter int unsigned QDEPTH = QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [15:0] code_unit
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // [7:0] out_byte
    output logic        o_m_axis_tlast
);

    logic    push, pop;
    t_job    job, head;
    t_q_stat q_stat;

    // classify units and build the byte list
    u2u8_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .i_code_unit  (i_s_axis_tdata),
        .i_final_unit (i_s_axis_tlast),
        .i_q_stat     (q_stat),
        .o_ready      (o_s_axis_tready),
        .o_push       (push),
        .o_job        (job)
    );

    // short queue between front and back
    u2u8_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job),
        .i_pop    (pop),
        .o_head   (head),
        .o_q_stat (q_stat)
    );

    // serialise bytes onto the output
    u2u8_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_head   (head),
        .i_tready (i_m_axis_tready),
        .o_pop    (pop),
        .o_tvalid (o_m_axis_tvalid),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

    // queue consistency
    `ASSERT_NEVER(a_q_full_empty, q_stat.full && q_stat.empty, "queue full and empty")
    `ASSERT_NEVER(a_push_full, push && q_stat.full, "push into full queue")
    `ASSERT_NEVER(a_pop_empty, pop && q_stat.empty, "pop from empty queue")
    `ASSERT_CLK(a_push_len, push |-> (job.nbytes != 3'd0 && job.nbytes <= 3'd6),
        "bad entry length")

endmodule

// ===== rtl/u2u8_front.sv =====
`timescale 1ns / 1ps

module u2u8_front import u2u8_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_code_unit,
    input  logic        i_final_unit,
    input  t_q_stat     i_q_stat,
    output logic        o_ready,
    output logic        o_push,
    output t_job        o_job
);

    logic        r_held_valid, n_held_valid;
    logic [15:0] r_held_high, n_held_high;

    logic            accept;
    logic            is_low, is_high, hold;
    logic [2:0][7:0] cur;
    logic [1:0]      cur_n;
    logic [20:0]     cp;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    assign is_low  = (i_code_unit >= LowBase) && (i_code_unit < SurrEnd);
    assign is_high = (i_code_unit >= HighBase) && (i_code_unit < LowBase);
    assign cp      = {1'b0, r_held_high[9:0], i_code_unit[9:0]} + SuppBase;

    // encoding of the current unit on its own
    always_comb begin
        cur   = '0;
        cur_n = 2'd0;
        hold  = 1'b0;
        priority if (i_code_unit < Lim1Byte) begin
            cur[0] = i_code_unit[7:0];
            cur_n  = 2'd1;
        end else if (i_code_unit < Lim2Byte) begin
            cur[0] = {3'b110, i_code_unit[10:6]};
            cur[1] = {2'b10, i_code_unit[5:0]};
            cur_n  = 2'd2;
        end else if (is_high && !i_final_unit) begin
            hold = 1'b1;
        end else begin
            cur   = enc3(i_code_unit);
            cur_n = 2'd3;
        end
    end

    // full word list for this unit, held surrogate first
    always_comb begin
        priority if (r_held_valid && is_low) begin
            o_job.bytes  = {16'h0000, enc4(cp)};
            o_job.nbytes = 3'd4;
        end else if (r_held_valid) begin
            o_job.bytes  = {cur, enc3(r_held_high)};
            o_job.nbytes = 3'd3 + {1'b0, cur_n};
        end else begin
            o_job.bytes  = {24'h000000, cur};
            o_job.nbytes = {1'b0, cur_n};
        end
    end

    assign o_push = accept && (o_job.nbytes != 3'd0);

    // held surrogate state
    always_comb begin
        n_held_valid = r_held_valid;
        n_held_high  = r_held_high;
        if (accept) begin
            n_held_valid = hold;
            if (hold) begin
                n_held_high = i_code_unit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_high  <= '0;
        end else begin
            r_held_valid <= n_held_valid;
            r_held_high  <= n_held_high;
        end
    end

endmodule

// ===== rtl/u2u8_queue.sv =====
`timescale 1ns / 1ps

module u2u8_queue import u2u8_pkg::*; #(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_q_stat
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    t_job            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_q_stat.full  = (r_count == FullCnt);
    assign o_q_stat.empty = (r_count == '0);

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/u2u8_back.sv =====
`timescale 1ns / 1ps

module u2u8_back import u2u8_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_stat i_q_stat,
    input  t_job    i_head,
    input  logic    i_tready,
    output logic    o_pop,
    output logic    o_tvalid,
    output t_byte   o_tdata,
    output logic    o_tlast
);

    logic [2:0] r_idx, n_idx;
    logic       r_valid;
    t_byte      r_byte;
    logic       r_last;

    logic load, last;

    assign load  = !i_q_stat.empty && (!r_valid || i_tready);
    assign last  = (r_idx == 3'(i_head.nbytes - 3'd1));
    assign o_pop = load && last;
    assign n_idx = last ? 3'd0 : r_idx + 3'd1;

    // output word register, one byte of the head entry per cycle while the output is ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= n_idx;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_byte;
    assign o_tlast  = r_last;

endmodule
